[rtl/dvc_pkg.sv]
// ----------------------------------------------------------------------------
// dvc_pkg
// Shared constants and types for the duplicate value counter.
// ----------------------------------------------------------------------------
package dvc_pkg;

    localparam int VALUE_W          = 6;   // width of an input value
    localparam int DUP_COUNT_W      = 7;   // width of a reported count
    localparam int DEF_VALUE_RANGE  = 64;
    localparam int DEF_MAX_ELEMENTS = 64;
    localparam int MAX_REPORT       = 32;  // results per report, at most
    localparam int REPORT_CNT_W     = $clog2(MAX_REPORT + 1);

    // one scan hit, or the end-of-scan marker, towards the result stage
    typedef struct packed {
        logic                   valid;
        logic                   is_end;
        logic [VALUE_W-1:0]     value;
        logic [DUP_COUNT_W-1:0] count;
    } hit_t;

endpackage

[rtl/dvc_if.sv]
// ----------------------------------------------------------------------------
// dvc_if
// Valid/ready channels for input items and for report results.
// ----------------------------------------------------------------------------
interface dvc_item_if import dvc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface dvc_result_if import dvc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [VALUE_W-1:0]     dup_value;
    logic [DUP_COUNT_W-1:0] dup_count;
    logic                   done_res;

    modport source (output valid, output dup_value, output dup_count, output done_res,
                    input ready);
    modport sink   (input valid, input dup_value, input dup_count, input done_res,
                    output ready);
endinterface

[rtl/dvc_hist_ram.sv]
// ----------------------------------------------------------------------------
// dvc_hist_ram
// Histogram store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dvc_hist_ram import dvc_pkg::*; #(
    parameter int  DEPTH  = DEF_VALUE_RANGE,
    parameter int  WIDTH  = 7,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];   // old data on a same-address write
        end
    end

endmodule

[rtl/dvc_report.sv]
// ----------------------------------------------------------------------------
// dvc_report
// Result stage: holds back one hit so the final one can carry done_res,
// and drives the registered result channel.
// ----------------------------------------------------------------------------
module dvc_report import dvc_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  hit_t           hit,
    output logic           hit_ready,
    dvc_result_if.source   results
);

    logic                   pend_valid_reg, pend_valid_next;
    logic [VALUE_W-1:0]     pend_value_reg, pend_value_next;
    logic [DUP_COUNT_W-1:0] pend_count_reg, pend_count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]     out_value_reg, out_value_next;
    logic [DUP_COUNT_W-1:0] out_count_reg, out_count_next;
    logic                   out_done_reg, out_done_next;
    logic                   out_free;
    logic                   take;

    assign out_free  = !out_valid_reg || results.ready;
    // a plain hit with nothing held back needs no output slot
    assign hit_ready = out_free || (!hit.is_end && !pend_valid_reg);
    assign take      = hit.valid && hit_ready;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_value_next = pend_value_reg;
        pend_count_next = pend_count_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_done_next   = out_done_reg;
        if (take && hit.is_end)
        begin
            out_valid_next  = 1'b1;
            out_done_next   = 1'b1;
            out_value_next  = pend_valid_reg ? pend_value_reg : '0;
            out_count_next  = pend_valid_reg ? pend_count_reg : '0;
            pend_valid_next = 1'b0;
        end
        else if (take)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_done_next  = 1'b0;
                out_value_next = pend_value_reg;
                out_count_next = pend_count_reg;
            end
            pend_valid_next = 1'b1;
            pend_value_next = hit.value;
            pend_count_next = hit.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_value_reg <= pend_value_next;
        pend_count_reg <= pend_count_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
        out_done_reg   <= out_done_next;
    end

    assign results.valid     = out_valid_reg;
    assign results.dup_value = out_value_reg;
    assign results.dup_count = out_count_reg;
    assign results.done_res  = out_done_reg;

endmodule

[rtl/duplicate_value_counter.sv]
// ----------------------------------------------------------------------------
// duplicate_value_counter
// Histogram-based duplicate counter with an ascending report after each set.
// ----------------------------------------------------------------------------
// Values arrive one per transfer and are counted in a single-port-pair
// histogram RAM by read-modify-write: one item per cycle while loading, with
// the write of one item forwarded to the read of the following ones. Only the
// first MAX_ELEMENTS values of a set are counted and counts saturate there;
// values at or above VALUE_RANGE are ignored, but their last mark still acts.
// After the transfer marked last, items are held off while the RAM is swept
// once in ascending order (one entry per cycle, longer while results stall),
// which reports every value seen more than once and clears each entry behind
// it. At most MAX_REPORT results are given per report, the final one with
// done_res set; with no duplicates the report is a single result of value 0,
// count 0, done_res 1. After reset the RAM is cleared in a pass over every
// entry, during which no item is taken.
// ----------------------------------------------------------------------------
module duplicate_value_counter import dvc_pkg::*; #(
    parameter int VALUE_RANGE  = DEF_VALUE_RANGE,
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
    input  logic         clk,
    input  logic         rst_n,
    dvc_item_if.sink     items,
    dvc_result_if.source results
);

    localparam int AW = $clog2(VALUE_RANGE);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    localparam logic [1:0] ST_INIT = 2'd0;   // clearing pass after reset
    localparam logic [1:0] ST_LOAD = 2'd1;   // counting items
    localparam logic [1:0] ST_SCAN = 2'd2;   // report sweep with clear
    localparam logic [1:0] ST_END  = 2'd3;   // hand over end of report

    logic [1:0]              state_reg, state_next;
    logic [AW:0]             ptr_reg, ptr_next;
    logic [CW-1:0]           total_reg, total_next;
    logic [REPORT_CNT_W-1:0] nres_reg, nres_next;

    // load stage: item whose count is being updated
    logic                    ld_valid_reg, ld_valid_next;
    logic [AW-1:0]           ld_addr_reg;
    // scan stage: entry whose count is being examined
    logic                    st_valid_reg, st_valid_next;
    logic [AW-1:0]           st_addr_reg, st_addr_next;
    // most recent RAM write, for forwarding
    logic                    wr_valid_reg;
    logic [AW-1:0]           wr_addr_reg;
    logic [CW-1:0]           wr_data_reg;

    logic                    accept;
    logic [AW+VALUE_W-1:0]   in_ext;
    logic                    in_range;
    logic                    counted;
    logic [AW-1:0]           in_addr;
    logic                    ptr_at_end;

    logic                    ram_we, ram_re;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    logic [CW-1:0]           ram_wdata, ram_rdata;
    logic [AW-1:0]           cur_addr;
    logic [CW-1:0]           cur_count;

    logic                    hit_need;
    logic                    advance;
    logic                    scan_issue;
    hit_t                    hit;
    logic                    hit_ready;
    logic [AW+VALUE_W-1:0]   hit_val_ext;
    logic [CW+DUP_COUNT_W-1:0] hit_cnt_ext;

    // input decode
    assign items.ready = (state_reg == ST_LOAD);
    assign accept      = items.valid && items.ready;
    assign in_ext      = {{AW{1'b0}}, items.value};
    assign in_range    = in_ext < (AW + VALUE_W)'(VALUE_RANGE);
    assign counted     = in_range && (total_reg < CW'(MAX_ELEMENTS));
    assign in_addr     = in_ext[AW-1:0];
    assign ptr_at_end  = (ptr_reg == (AW + 1)'(VALUE_RANGE));

    // the newest write to an address always wins over RAM read data
    assign cur_addr  = ld_valid_reg ? ld_addr_reg : st_addr_reg;
    assign cur_count = (wr_valid_reg && wr_addr_reg == cur_addr) ? wr_data_reg : ram_rdata;

    // scan stage: a hit stalls the sweep until the result stage takes it
    assign hit_need   = st_valid_reg && (cur_count > CW'(1))
                        && (nres_reg < REPORT_CNT_W'(MAX_REPORT));
    assign advance    = !st_valid_reg || !hit_need || hit_ready;
    assign scan_issue = (state_reg == ST_SCAN) && !ptr_at_end && advance;

    assign hit_val_ext = {{VALUE_W{1'b0}}, st_addr_reg};
    assign hit_cnt_ext = {{DUP_COUNT_W{1'b0}}, cur_count};

    always_comb
    begin
        hit.valid  = hit_need || (state_reg == ST_END);
        hit.is_end = (state_reg == ST_END);
        hit.value  = hit_val_ext[VALUE_W-1:0];
        hit.count  = hit_cnt_ext[DUP_COUNT_W-1:0];
    end

    // RAM port control
    always_comb
    begin
        ram_re    = scan_issue || (accept && counted);
        ram_raddr = scan_issue ? ptr_reg[AW-1:0] : in_addr;
        ram_we    = 1'b0;
        ram_waddr = cur_addr;
        ram_wdata = '0;
        if (state_reg == ST_INIT)
        begin
            ram_we    = 1'b1;
            ram_waddr = ptr_reg[AW-1:0];
        end
        else if (ld_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_wdata = (cur_count < CW'(MAX_ELEMENTS)) ? cur_count + CW'(1) : cur_count;
        end
        else if (st_valid_reg && advance)
        begin
            ram_we = 1'b1;   // clear behind the sweep
        end
    end

    // sequencing
    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        total_next    = total_reg;
        nres_next     = nres_reg;
        ld_valid_next = accept && counted;
        st_valid_next = st_valid_reg;
        st_addr_next  = st_addr_reg;

        if (advance)
        begin
            st_valid_next = scan_issue;
            st_addr_next  = ptr_reg[AW-1:0];
        end
        if (scan_issue)
        begin
            ptr_next = ptr_reg + (AW + 1)'(1);
        end
        if (hit_need && hit_ready)
        begin
            nres_next = nres_reg + REPORT_CNT_W'(1);
        end

        case (state_reg)
            ST_INIT:
            begin
                ptr_next = ptr_reg + (AW + 1)'(1);
                if (ptr_reg == (AW + 1)'(VALUE_RANGE - 1))
                begin
                    ptr_next   = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (accept)
                begin
                    total_next = items.last ? '0 : total_reg + CW'(counted);
                    if (items.last)
                    begin
                        ptr_next   = '0;
                        nres_next  = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (ptr_at_end && !st_valid_reg)
                begin
                    state_next = ST_END;
                end
            end
            ST_END:
            begin
                if (hit_ready)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            ptr_reg      <= '0;
            total_reg    <= '0;
            nres_reg     <= '0;
            ld_valid_reg <= 1'b0;
            st_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            total_reg    <= total_next;
            nres_reg     <= nres_next;
            ld_valid_reg <= ld_valid_next;
            st_valid_reg <= st_valid_next;
            if (ram_we)
            begin
                wr_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        st_addr_reg <= st_addr_next;
        if (accept)
        begin
            ld_addr_reg <= in_addr;
        end
        if (ram_we)
        begin
            wr_addr_reg <= ram_waddr;
            wr_data_reg <= ram_wdata;
        end
    end

    dvc_hist_ram #(
        .DEPTH (VALUE_RANGE),
        .WIDTH (CW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dvc_report u_report (
        .clk       (clk),
        .rst_n     (rst_n),
        .hit       (hit),
        .hit_ready (hit_ready),
        .results   (results)
    );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the duplicate value counter. Data sets are queued
// up front and sent over the item channel; a local histogram model predicts
// each report when the transfer marked last is seen, and every result
// transfer is checked field by field against the oldest prediction. Both
// channels idle or stall at random in several phases.
// ----------------------------------------------------------------------------
module testbench;
    import dvc_pkg::*;

    localparam int VALUE_RANGE  = DEF_VALUE_RANGE;
    localparam int MAX_ELEMENTS = DEF_MAX_ELEMENTS;
    localparam int STIM_ITEMS   = 270;              // rough size of the random part
    localparam int DRAIN_CYCLES = 2 * (VALUE_RANGE + 3) + 16;
    localparam int TIMEOUT_NS   = 4_000_000;        // far beyond a slow run
    localparam int MAX_SHOWN    = 10;

    // one element of a data set, as queued for the driver
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } set_item_t;

    // one report entry as the block should give it
    typedef struct packed {
        logic [VALUE_W-1:0]     value;
        logic [DUP_COUNT_W-1:0] count;
        logic                   done;
    } dup_entry_t;

    // ------------------------------------------------------------------------
    // Clock, reset and channel wiring
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #10 clk = ~clk;

    // Local copies of everything the bench drives; initialisers give known
    // values from time zero, before the first clock edge.
    logic               item_valid_q = 1'b0;
    logic [VALUE_W-1:0] item_value_q = '0;
    logic               item_last_q  = 1'b0;
    logic               res_ready_q  = 1'b0;

    dvc_item_if   item_ch();
    dvc_result_if result_ch();

    assign item_ch.valid   = item_valid_q;
    assign item_ch.value   = item_value_q;
    assign item_ch.last    = item_last_q;
    assign result_ch.ready = res_ready_q;

    duplicate_value_counter #(
        .VALUE_RANGE  (VALUE_RANGE),
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .results (result_ch)
    );

    // ------------------------------------------------------------------------
    // Queues and counters
    // ------------------------------------------------------------------------
    set_item_t  pending_items[$];   // filled once at time zero, drained by the driver
    dup_entry_t expected_dups[$];   // predicted report entries, oldest first

    int n_stim      = 0;    // items queued in total
    int n_items_in  = 0;    // item transfers seen (NBA, read by the driver)
    int n_results   = 0;    // result transfers checked
    int n_fail      = 0;
    int n_sets      = 0;
    int n_empty     = 0;    // reports with no duplicate
    int n_saturated = 0;    // entries whose count hit the element limit
    int n_full      = 0;    // reports of MAX_REPORT entries

    // ------------------------------------------------------------------------
    // Histogram model: its own copy of the tallies and the set length
    // ------------------------------------------------------------------------
    logic [DUP_COUNT_W-1:0] tally [VALUE_RANGE];
    int                     set_len = 0;

    initial
    begin
        for (int i = 0; i < VALUE_RANGE; i++)
            tally[i] = '0;
    end

    // Count one accepted element; on the last of a set, queue the report in
    // ascending value order and clear the histogram for the next set.
    task automatic tally_item(input logic [VALUE_W-1:0] v, input logic lst);
        int         n_hits;
        int         k;
        dup_entry_t e;
        n_hits = 0;
        k      = 0;
        // values beyond the range and elements past the set limit are dropped
        if (int'(v) < VALUE_RANGE && set_len < MAX_ELEMENTS)
        begin
            if (int'(tally[v]) < MAX_ELEMENTS)
                tally[v] = tally[v] + 1'b1;
            set_len++;
        end
        if (lst)
        begin
            n_sets++;
            for (int i = 0; i < VALUE_RANGE; i++)
                if (tally[i] > 1)
                    n_hits++;
            if (n_hits > MAX_REPORT)
                n_hits = MAX_REPORT;
            if (n_hits == 0)
            begin
                // empty report: a lone done entry of value 0, count 0
                e.value = '0;
                e.count = '0;
                e.done  = 1'b1;
                expected_dups.push_back(e);
                n_empty++;
            end
            else
            begin
                for (int i = 0; i < VALUE_RANGE && k < n_hits; i++)
                begin
                    if (tally[i] > 1)
                    begin
                        e.value = VALUE_W'(i);
                        e.count = tally[i];
                        e.done  = (k == n_hits - 1);
                        expected_dups.push_back(e);
                        if (int'(tally[i]) == MAX_ELEMENTS)
                            n_saturated++;
                        k++;
                    end
                end
                if (n_hits == MAX_REPORT)
                    n_full++;
            end
            for (int i = 0; i < VALUE_RANGE; i++)
                tally[i] = '0;
            set_len = 0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Idle and stall rates per phase; the phase follows stimulus progress
    // ------------------------------------------------------------------------
    function automatic int phase_now(input int done_items);
        int p;
        p = (n_stim == 0) ? 0 : (done_items * 4) / n_stim;
        return (p > 3) ? 3 : p;
    endfunction

    // phase 0: free flow; 1: sender gaps; 2: receiver stalls; 3: light both
    function automatic int sender_idle_pct(input int ph);
        case (ph)
            1:       return 62;
            3:       return 9;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct(input int ph);
        case (ph)
            2:       return 62;
            3:       return 9;
            default: return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents the next queued item once the slot is free
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        set_item_t nxt;
        logic      go;
        if (!rst_n)
        begin
            item_valid_q <= 1'b0;
            item_value_q <= '0;
            item_last_q  <= 1'b0;
        end
        else if (!item_valid_q || item_ch.ready)
        begin
            // slot free: either nothing shown, or a transfer happens this edge
            go = (pending_items.size() != 0) &&
                 ($urandom_range(0, 99) >= sender_idle_pct(phase_now(n_items_in)));
            if (go)
            begin
                nxt = pending_items.pop_front();
                item_valid_q <= 1'b1;
                item_value_q <= nxt.value;
                item_last_q  <= nxt.last;
            end
            else
            begin
                item_valid_q <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on item transfers, checks result transfers, and
    // drives the result ready. Both sides are sampled here so that a
    // prediction never races its check.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        dup_entry_t want;
        dup_entry_t got;
        if (!rst_n)
        begin
            res_ready_q <= 1'b0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                tally_item(item_ch.value, item_ch.last);
                n_items_in <= n_items_in + 1;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                got.value = result_ch.dup_value;
                got.count = result_ch.dup_count;
                got.done  = result_ch.done_res;
                if (expected_dups.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= MAX_SHOWN)
                        $display("[%0t] unexpected result: value %0d count %0d done %0b",
                                 $realtime, got.value, got.count, got.done);
                end
                else
                begin
                    want = expected_dups.pop_front();
                    if (got.value !== want.value || got.count !== want.count ||
                        got.done !== want.done)
                    begin
                        n_fail++;
                        if (n_fail <= MAX_SHOWN)
                        begin
                            $write("[%0t] result %0d mismatch: expected value %0d ",
                                   $realtime, n_results, want.value);
                            $display("count %0d done %0b, got value %0d count %0d done %0b",
                                     want.count, want.done, got.value, got.count,
                                     got.done);
                        end
                    end
                end
                n_results++;
            end
            res_ready_q <= ($urandom_range(0, 99) >=
                            receiver_stall_pct(phase_now(n_items_in)));
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic queue_item(input int v, input logic lst);
        set_item_t it;
        it.value = VALUE_W'(v);
        it.last  = lst;
        pending_items.push_back(it);
        n_stim++;
    endtask

    // Short random set; a narrow window of values makes duplicates likely.
    task automatic queue_random_set(input int len);
        int base;
        int span;
        base = $urandom_range(0, VALUE_RANGE - 1);
        span = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 7) : VALUE_RANGE - 1;
        for (int i = 0; i < len; i++)
            queue_item((base + $urandom_range(0, span)) % VALUE_RANGE, i == len - 1);
    endtask

    initial
    begin : stimulus
        int pool[VALUE_RANGE];
        int seq[$];
        int j;
        int tmp;
        int fill;
        int kind;
        int rep;
        logic sat_done;
        logic pairs_done;

        sat_done   = 1'b0;
        pairs_done = 1'b0;

        // --- directed sets ---
        queue_item(0, 1'b1);                                 // single element: empty report
        queue_item(VALUE_RANGE - 1, 1'b0);                   // top value twice
        queue_item(VALUE_RANGE - 1, 1'b1);
        queue_item(0, 1'b0);                                 // both extremes duplicated
        queue_item(0, 1'b0);
        queue_item(0, 1'b0);
        queue_item(VALUE_RANGE - 1, 1'b0);
        queue_item(VALUE_RANGE - 1, 1'b1);
        queue_item(5, 1'b0);                                 // all distinct: empty report
        queue_item(9, 1'b0);
        queue_item(17, 1'b0);
        queue_item(42, 1'b1);
        queue_item(21, 1'b0);                                // alternating bit patterns
        queue_item(42, 1'b0);
        queue_item(21, 1'b0);
        queue_item(42, 1'b0);
        queue_item(21, 1'b1);

        // --- random sets, with two long shapes mixed in ---
        fill = n_stim + STIM_ITEMS;
        while (n_stim < fill || !sat_done || !pairs_done)
        begin
            kind = $urandom_range(0, 15);
            if ((kind == 0 || n_stim >= fill) && !sat_done)
            begin
                // one value repeated past the set limit: count saturates and
                // the overflow elements are dropped
                rep = MAX_ELEMENTS + $urandom_range(2, 6);
                tmp = $urandom_range(0, VALUE_RANGE - 1);
                for (int i = 0; i < rep; i++)
                    queue_item(tmp, i == rep - 1);
                sat_done = 1'b1;
            end
            else if ((kind == 1 || n_stim >= fill) && !pairs_done)
            begin
                // MAX_REPORT + 1 distinct values in pairs, shuffled: the last
                // pair falls past the element limit, so the report is full
                for (int i = 0; i < VALUE_RANGE; i++)
                    pool[i] = i;
                for (int i = VALUE_RANGE - 1; i > 0; i--)
                begin
                    j       = $urandom_range(0, i);
                    tmp     = pool[i];
                    pool[i] = pool[j];
                    pool[j] = tmp;
                end
                seq.delete();
                for (int i = 0; i < MAX_REPORT + 1; i++)
                begin
                    seq.push_back(pool[i]);
                    seq.push_back(pool[i]);
                end
                // shuffle the first MAX_ELEMENTS; keep the spare pair at the end
                for (int i = MAX_ELEMENTS - 1; i > 0; i--)
                begin
                    j      = $urandom_range(0, i);
                    tmp    = seq[i];
                    seq[i] = seq[j];
                    seq[j] = tmp;
                end
                for (int i = 0; i < seq.size(); i++)
                    queue_item(seq[i], i == seq.size() - 1);
                pairs_done = 1'b1;
            end
            else if (n_stim < fill)
            begin
                queue_random_set((kind < 13) ? $urandom_range(1, 10) : $urandom_range(11, 30));
            end
        end

        // --- reset, then wait for every item and every predicted result ---
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (n_items_in < n_stim || expected_dups.size() != 0)
            @(posedge clk);
        // let any stray result show up before judging
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d sets of %0d items and %0d checked results:", n_sets,
                 n_stim, n_results);
        $display("  %0d empty reports, %0d full reports, %0d saturated counts, %0d failures",
                 n_empty, n_full, n_saturated, n_fail);
        if (n_fail == 0 && expected_dups.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("[%0t] timeout: %0d of %0d items in, %0d results still expected",
                 $realtime, n_items_in, n_stim, expected_dups.size());
        $display("Verification failed");
        $finish;
    end

endmodule
